// ----- src/spot_pkg.sv -----
package spot_pkg;

   localparam int CoordWidth  = 16;
   localparam int RadiusWidth = 15;
   localparam int RsWidth     = RadiusWidth + 1;
   localparam int R2Width     = 2 * RsWidth;
   localparam int DiffWidth   = CoordWidth + 1;
   localparam int SqWidth     = 2 * CoordWidth;
   localparam int L2Width     = SqWidth + 1;
   localparam int DotWidth    = L2Width + 1;
   localparam int PdWidth     = 2 * DiffWidth;
   localparam int ProdWidth   = 2 * L2Width;
   localparam int RhsWidth    = ProdWidth + 1;
   localparam int BoundWidth  = CoordWidth + 1;
   localparam int RdWidth     = CoordWidth + 2;
   localparam int RsqWidth    = 2 * RdWidth;
   localparam int Rd2Width    = RsqWidth + 1;

   localparam int NumSeg      = 4;
   localparam int NumRect     = 2;
   localparam int QueueDepth  = 4;
   localparam int OutDepth    = 8;
   localparam int NumStages   = 5;
   localparam int PendWidth   = $clog2(OutDepth + 1);

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [DiffWidth-1:0]  diff_type;
   typedef logic signed [BoundWidth-1:0] bound_type;
   typedef logic signed [RdWidth-1:0]    rd_type;
   typedef logic [RsWidth-1:0]           rs_type;

   typedef enum logic [2:0] {
      OP_RECT_RECT      = 3'd0,
      OP_CIRCLE_CIRCLE  = 3'd1,
      OP_CAPSULE_CAPSULE = 3'd2,
      OP_RECT_CIRCLE    = 3'd3,
      OP_CAPSULE_CIRCLE = 3'd4,
      OP_CAPSULE_RECT   = 3'd5
   } op_type;

   // point p against segment a..b
   typedef struct packed {
      logic      en;
      coord_type px;
      coord_type py;
      coord_type ax;
      coord_type ay;
      coord_type bx;
      coord_type by;
   } seg_lane_type;

   // point p against rect with center c, half extents h
   typedef struct packed {
      logic      en;
      coord_type px;
      coord_type py;
      coord_type cx;
      coord_type cy;
      coord_type hx;
      coord_type hy;
   } rect_lane_type;

   typedef struct packed {
      logic                         box_hit;
      rs_type                       r;
      seg_lane_type  [NumSeg-1:0]   seg;
      rect_lane_type [NumRect-1:0]  rect;
   } cmd_type;

   typedef struct packed {
      logic                 issue;
      logic [PendWidth-1:0] pending;
      logic [PendWidth-1:0] out_count;
   } back_status_type;

   function automatic diff_type sub_diff(coord_type a, coord_type b);
      return diff_type'(a) - diff_type'(b);
   endfunction

   function automatic seg_lane_type mk_seg(coord_type px, coord_type py, coord_type ax,
                                           coord_type ay, coord_type bx, coord_type by);
      seg_lane_type s;
      s.en = 1'b1;
      s.px = px;
      s.py = py;
      s.ax = ax;
      s.ay = ay;
      s.bx = bx;
      s.by = by;
      return s;
   endfunction

   function automatic rect_lane_type mk_rect(coord_type px, coord_type py, coord_type cx,
                                             coord_type cy, coord_type hx, coord_type hy);
      rect_lane_type s;
      s.en = 1'b1;
      s.px = px;
      s.py = py;
      s.cx = cx;
      s.cy = cy;
      s.hx = hx;
      s.hy = hy;
      return s;
   endfunction

endpackage

// ----- src/shape_pair_overlap_test_unit.sv -----
// Channel   | Handshake        | Ports
// ----------+------------------+------------------------------------------------
// request   | push / full      | req_op, req_a_*, req_b_* (coords, radius)
// response  | pop / empty      | rsp_hit
//
// One pair per cycle sustained while the consumer keeps popping. A beat passes
// through the command queue and the arithmetic pipeline before it reaches the
// response queue.
// The back end issues only while it holds a free response slot (eight slots
// cover pipeline and queue), so a stalled consumer backs up into the command
// queue and then raises full. Reset empties both queues and the pipeline.
module shape_pair_overlap_test_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [2:0]                        req_op,
   input  spot_pkg::coord_type               req_a_x0,
   input  spot_pkg::coord_type               req_a_y0,
   input  spot_pkg::coord_type               req_a_x1,
   input  spot_pkg::coord_type               req_a_y1,
   input  logic [spot_pkg::RadiusWidth-1:0]  req_a_radius,
   input  spot_pkg::coord_type               req_b_x0,
   input  spot_pkg::coord_type               req_b_y0,
   input  spot_pkg::coord_type               req_b_x1,
   input  spot_pkg::coord_type               req_b_y1,
   input  logic [spot_pkg::RadiusWidth-1:0]  req_b_radius,
   output logic                              empty,
   input  logic                              pop,
   output logic                              rsp_hit
);
   import spot_pkg::*;

   cmd_type         front_cmd;
   cmd_type         q_head;
   logic            q_empty;
   back_status_type back_status;

   spot_front u_front (
      .req_op       (req_op),
      .req_a_x0     (req_a_x0),
      .req_a_y0     (req_a_y0),
      .req_a_x1     (req_a_x1),
      .req_a_y1     (req_a_y1),
      .req_a_radius (req_a_radius),
      .req_b_x0     (req_b_x0),
      .req_b_y0     (req_b_y0),
      .req_b_x1     (req_b_x1),
      .req_b_y1     (req_b_y1),
      .req_b_radius (req_b_radius),
      .cmd          (front_cmd)
   );

   spot_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_cmd),
      .pop       (back_status.issue),
      .full      (full),
      .empty     (q_empty),
      .head      (q_head)
   );

   spot_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .rsp_hit   (rsp_hit),
      .status    (back_status)
   );

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      back_status.pending <= PendWidth'(OutDepth))
      else $error("pending beats exceed response slots");

   a_issue_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      back_status.issue |-> !q_empty)
      else $error("issue from empty command queue");

   a_count_within_pending: assert property (@(posedge clock) disable iff (reset)
      back_status.out_count <= back_status.pending)
      else $error("response queue holds more than was issued");

   a_pop_frees_credit: assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && !back_status.issue) |=>
         back_status.pending == $past(back_status.pending) - 1'b1)
      else $error("pop did not return a credit");

endmodule

// ----- src/spot_front.sv -----
module spot_front (
   input  logic [2:0]                      req_op,
   input  spot_pkg::coord_type             req_a_x0,
   input  spot_pkg::coord_type             req_a_y0,
   input  spot_pkg::coord_type             req_a_x1,
   input  spot_pkg::coord_type             req_a_y1,
   input  logic [spot_pkg::RadiusWidth-1:0] req_a_radius,
   input  spot_pkg::coord_type             req_b_x0,
   input  spot_pkg::coord_type             req_b_y0,
   input  spot_pkg::coord_type             req_b_x1,
   input  spot_pkg::coord_type             req_b_y1,
   input  logic [spot_pkg::RadiusWidth-1:0] req_b_radius,
   output spot_pkg::cmd_type               cmd
);
   import spot_pkg::*;

   op_type   op;
   diff_type dx_raw;
   diff_type dy_raw;
   diff_type dx_abs;
   diff_type dy_abs;
   diff_type ext_x;
   diff_type ext_y;
   rs_type   rs;

   // rect-rect is a plain compare, resolved here
   always_comb begin
      op     = op_type'(req_op);
      dx_raw = sub_diff(req_a_x0, req_b_x0);
      dy_raw = sub_diff(req_a_y0, req_b_y0);
      dx_abs = (dx_raw < 0) ? -dx_raw : dx_raw;
      dy_abs = (dy_raw < 0) ? -dy_raw : dy_raw;
      ext_x  = diff_type'(req_a_x1) + diff_type'(req_b_x1);
      ext_y  = diff_type'(req_a_y1) + diff_type'(req_b_y1);
      rs     = rs_type'(req_a_radius) + rs_type'(req_b_radius);

      cmd         = '0;
      cmd.box_hit = (op == OP_RECT_RECT) && (dx_abs <= ext_x) && (dy_abs <= ext_y);

      unique case (op)
         OP_RECT_RECT: begin
         end
         OP_CIRCLE_CIRCLE: begin
            // circle pair as a degenerate segment
            cmd.r      = rs;
            cmd.seg[0] = mk_seg(req_a_x0, req_a_y0, req_b_x0, req_b_y0, req_b_x0, req_b_y0);
         end
         OP_CAPSULE_CAPSULE: begin
            cmd.r      = rs;
            cmd.seg[0] = mk_seg(req_a_x0, req_a_y0, req_b_x0, req_b_y0, req_b_x1, req_b_y1);
            cmd.seg[1] = mk_seg(req_a_x1, req_a_y1, req_b_x0, req_b_y0, req_b_x1, req_b_y1);
            cmd.seg[2] = mk_seg(req_b_x0, req_b_y0, req_a_x0, req_a_y0, req_a_x1, req_a_y1);
            cmd.seg[3] = mk_seg(req_b_x1, req_b_y1, req_a_x0, req_a_y0, req_a_x1, req_a_y1);
         end
         OP_RECT_CIRCLE: begin
            cmd.r       = rs_type'(req_b_radius);
            cmd.rect[0] = mk_rect(req_b_x0, req_b_y0, req_a_x0, req_a_y0, req_a_x1, req_a_y1);
         end
         OP_CAPSULE_CIRCLE: begin
            cmd.r      = rs;
            cmd.seg[0] = mk_seg(req_b_x0, req_b_y0, req_a_x0, req_a_y0, req_a_x1, req_a_y1);
         end
         OP_CAPSULE_RECT: begin
            cmd.r       = rs_type'(req_a_radius);
            cmd.rect[0] = mk_rect(req_a_x0, req_a_y0, req_b_x0, req_b_y0, req_b_x1, req_b_y1);
            cmd.rect[1] = mk_rect(req_a_x1, req_a_y1, req_b_x0, req_b_y0, req_b_x1, req_b_y1);
            cmd.seg[0]  = mk_seg(req_b_x0, req_b_y0, req_a_x0, req_a_y0, req_a_x1, req_a_y1);
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- src/spot_cmd_queue.sv -----
module spot_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  spot_pkg::cmd_type push_data,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output spot_pkg::cmd_type head
);
   import spot_pkg::*;

   localparam int PtrWidth = $clog2(QueueDepth);
   localparam int CntWidth = $clog2(QueueDepth + 1);

   cmd_type               mem_ff [QueueDepth];
   logic [PtrWidth-1:0]   wptr_ff, wptr_in;
   logic [PtrWidth-1:0]   rptr_ff, rptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full    = (count_ff == CntWidth'(QueueDepth));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + CntWidth'(do_push) - CntWidth'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/spot_back.sv -----
module spot_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_empty,
   input  spot_pkg::cmd_type         q_head,
   input  logic                      rsp_pop,
   output logic                      rsp_empty,
   output logic                      rsp_hit,
   output spot_pkg::back_status_type status
);
   import spot_pkg::*;

   localparam int PtrWidth = $clog2(OutDepth);

   logic                 issue;
   logic                 out_push;
   logic                 out_pop;
   logic                 lane_hit;
   logic [NumStages-1:0] valid_ff;
   logic [PendWidth-1:0] pending_ff, pending_in;
   logic [PendWidth-1:0] out_count_ff, out_count_in;
   logic [PtrWidth-1:0]  out_wptr_ff, out_wptr_in;
   logic [PtrWidth-1:0]  out_rptr_ff, out_rptr_in;
   logic                 out_mem_ff [OutDepth];

   // shared radius path and rect-rect result
   logic                 box_ff [NumStages];
   rs_type               s1_r_ff;
   logic [R2Width-1:0]   s2_r2_ff, s3_r2_ff, s4_r2_ff;

   // segment lanes
   logic                 seg_en_ff [NumStages][NumSeg];
   diff_type             s1_abx_ff [NumSeg], s1_aby_ff [NumSeg];
   diff_type             s1_pax_ff [NumSeg], s1_pay_ff [NumSeg];
   diff_type             s1_pbx_ff [NumSeg], s1_pby_ff [NumSeg];
   logic [SqWidth-1:0]   s2_sabx_ff [NumSeg], s2_saby_ff [NumSeg];
   logic [SqWidth-1:0]   s2_spax_ff [NumSeg], s2_spay_ff [NumSeg];
   logic [SqWidth-1:0]   s2_spbx_ff [NumSeg], s2_spby_ff [NumSeg];
   logic signed [PdWidth-1:0]  s2_pdx_ff [NumSeg], s2_pdy_ff [NumSeg];
   logic [L2Width-1:0]   s3_l2_ff [NumSeg], s3_pa2_ff [NumSeg], s3_pb2_ff [NumSeg];
   logic signed [DotWidth-1:0] s3_dot_ff [NumSeg];
   logic [ProdWidth-1:0] s4_pl_ff [NumSeg], s4_rl_ff [NumSeg], s4_dd_ff [NumSeg];
   logic                 s4_use_pa_ff [NumSeg], s4_use_pb_ff [NumSeg];
   logic                 s4_pa_ok_ff [NumSeg], s4_pb_ok_ff [NumSeg];
   logic                 s5_seg_near_ff [NumSeg];

   // rect lanes
   logic                 rect_en_ff [NumStages][NumRect];
   bound_type            s1_lox_ff [NumRect], s1_hix_ff [NumRect];
   bound_type            s1_loy_ff [NumRect], s1_hiy_ff [NumRect];
   coord_type            s1_px_ff [NumRect], s1_py_ff [NumRect];
   coord_type            s2_px_ff [NumRect], s2_py_ff [NumRect];
   bound_type            s2_qx_ff [NumRect], s2_qy_ff [NumRect];
   rd_type               s3_dx_ff [NumRect], s3_dy_ff [NumRect];
   logic [RsqWidth-1:0]  s4_sx_ff [NumRect], s4_sy_ff [NumRect];
   logic                 s5_rect_near_ff [NumRect];

   assign issue    = !q_empty && (pending_ff < PendWidth'(OutDepth));
   assign out_push = valid_ff[NumStages-1];
   assign rsp_empty = (out_count_ff == '0);
   assign out_pop  = rsp_pop && !rsp_empty;
   assign rsp_hit  = out_mem_ff[out_rptr_ff];

   assign status.issue     = issue;
   assign status.pending   = pending_ff;
   assign status.out_count = out_count_ff;

   always_comb begin
      lane_hit = box_ff[NumStages-1];
      for (int i = 0; i < NumSeg; i++) begin
         lane_hit = lane_hit | (seg_en_ff[NumStages-1][i] & s5_seg_near_ff[i]);
      end
      for (int j = 0; j < NumRect; j++) begin
         lane_hit = lane_hit | (rect_en_ff[NumStages-1][j] & s5_rect_near_ff[j]);
      end
      pending_in   = pending_ff + PendWidth'(issue) - PendWidth'(out_pop);
      out_count_in = out_count_ff + PendWidth'(out_push) - PendWidth'(out_pop);
      out_wptr_in  = out_push ? out_wptr_ff + 1'b1 : out_wptr_ff;
      out_rptr_in  = out_pop ? out_rptr_ff + 1'b1 : out_rptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         pending_ff   <= '0;
         out_count_ff <= '0;
         out_wptr_ff  <= '0;
         out_rptr_ff  <= '0;
      end else begin
         valid_ff     <= {valid_ff[NumStages-2:0], issue};
         pending_ff   <= pending_in;
         out_count_ff <= out_count_in;
         out_wptr_ff  <= out_wptr_in;
         out_rptr_ff  <= out_rptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_mem_ff[out_wptr_ff] <= lane_hit;
      end
   end

   // datapath, advances every cycle; valid_ff marks live beats
   always_ff @(posedge clock) begin
      box_ff[0] <= q_head.box_hit;
      for (int k = 1; k < NumStages; k++) begin
         box_ff[k] <= box_ff[k-1];
         for (int i = 0; i < NumSeg; i++) begin
            seg_en_ff[k][i] <= seg_en_ff[k-1][i];
         end
         for (int j = 0; j < NumRect; j++) begin
            rect_en_ff[k][j] <= rect_en_ff[k-1][j];
         end
      end

      s1_r_ff  <= q_head.r;
      s2_r2_ff <= R2Width'(s1_r_ff) * R2Width'(s1_r_ff);
      s3_r2_ff <= s2_r2_ff;
      s4_r2_ff <= s3_r2_ff;

      for (int i = 0; i < NumSeg; i++) begin
         seg_en_ff[0][i] <= q_head.seg[i].en;
         // stage 1: offsets
         s1_abx_ff[i] <= sub_diff(q_head.seg[i].bx, q_head.seg[i].ax);
         s1_aby_ff[i] <= sub_diff(q_head.seg[i].by, q_head.seg[i].ay);
         s1_pax_ff[i] <= sub_diff(q_head.seg[i].px, q_head.seg[i].ax);
         s1_pay_ff[i] <= sub_diff(q_head.seg[i].py, q_head.seg[i].ay);
         s1_pbx_ff[i] <= sub_diff(q_head.seg[i].px, q_head.seg[i].bx);
         s1_pby_ff[i] <= sub_diff(q_head.seg[i].py, q_head.seg[i].by);
         // stage 2: squares and dot terms
         s2_sabx_ff[i] <= SqWidth'(s1_abx_ff[i] * s1_abx_ff[i]);
         s2_saby_ff[i] <= SqWidth'(s1_aby_ff[i] * s1_aby_ff[i]);
         s2_spax_ff[i] <= SqWidth'(s1_pax_ff[i] * s1_pax_ff[i]);
         s2_spay_ff[i] <= SqWidth'(s1_pay_ff[i] * s1_pay_ff[i]);
         s2_spbx_ff[i] <= SqWidth'(s1_pbx_ff[i] * s1_pbx_ff[i]);
         s2_spby_ff[i] <= SqWidth'(s1_pby_ff[i] * s1_pby_ff[i]);
         s2_pdx_ff[i]  <= PdWidth'(s1_pax_ff[i] * s1_abx_ff[i]);
         s2_pdy_ff[i]  <= PdWidth'(s1_pay_ff[i] * s1_aby_ff[i]);
         // stage 3: sums
         s3_l2_ff[i]  <= L2Width'(s2_sabx_ff[i]) + L2Width'(s2_saby_ff[i]);
         s3_pa2_ff[i] <= L2Width'(s2_spax_ff[i]) + L2Width'(s2_spay_ff[i]);
         s3_pb2_ff[i] <= L2Width'(s2_spbx_ff[i]) + L2Width'(s2_spby_ff[i]);
         s3_dot_ff[i] <= DotWidth'(s2_pdx_ff[i]) + DotWidth'(s2_pdy_ff[i]);
         // stage 4: products and region select; dot is only used when positive
         s4_pl_ff[i]  <= ProdWidth'(s3_pa2_ff[i]) * ProdWidth'(s3_l2_ff[i]);
         s4_rl_ff[i]  <= ProdWidth'(s3_r2_ff) * ProdWidth'(s3_l2_ff[i]);
         s4_dd_ff[i]  <= ProdWidth'(s3_dot_ff[i][L2Width-1:0]) *
                         ProdWidth'(s3_dot_ff[i][L2Width-1:0]);
         s4_use_pa_ff[i] <= (s3_l2_ff[i] == '0) || (s3_dot_ff[i] <= 0);
         s4_use_pb_ff[i] <= (s3_dot_ff[i][L2Width-1:0] >= s3_l2_ff[i]);
         s4_pa_ok_ff[i]  <= (s3_pa2_ff[i] <= L2Width'(s3_r2_ff));
         s4_pb_ok_ff[i]  <= (s3_pb2_ff[i] <= L2Width'(s3_r2_ff));
         // stage 5
         if (s4_use_pa_ff[i]) begin
            s5_seg_near_ff[i] <= s4_pa_ok_ff[i];
         end else if (s4_use_pb_ff[i]) begin
            s5_seg_near_ff[i] <= s4_pb_ok_ff[i];
         end else begin
            s5_seg_near_ff[i] <= RhsWidth'(s4_pl_ff[i]) <=
                                 RhsWidth'(s4_rl_ff[i]) + RhsWidth'(s4_dd_ff[i]);
         end
      end

      for (int j = 0; j < NumRect; j++) begin
         rect_en_ff[0][j] <= q_head.rect[j].en;
         s1_lox_ff[j] <= bound_type'(q_head.rect[j].cx) - bound_type'(q_head.rect[j].hx);
         s1_hix_ff[j] <= bound_type'(q_head.rect[j].cx) + bound_type'(q_head.rect[j].hx);
         s1_loy_ff[j] <= bound_type'(q_head.rect[j].cy) - bound_type'(q_head.rect[j].hy);
         s1_hiy_ff[j] <= bound_type'(q_head.rect[j].cy) + bound_type'(q_head.rect[j].hy);
         s1_px_ff[j]  <= q_head.rect[j].px;
         s1_py_ff[j]  <= q_head.rect[j].py;
         // low bound is tested first; when bounds cross, points under it take it, others the high bound
         if (bound_type'(s1_px_ff[j]) < s1_lox_ff[j]) begin
            s2_qx_ff[j] <= s1_lox_ff[j];
         end else if (bound_type'(s1_px_ff[j]) > s1_hix_ff[j]) begin
            s2_qx_ff[j] <= s1_hix_ff[j];
         end else begin
            s2_qx_ff[j] <= bound_type'(s1_px_ff[j]);
         end
         if (bound_type'(s1_py_ff[j]) < s1_loy_ff[j]) begin
            s2_qy_ff[j] <= s1_loy_ff[j];
         end else if (bound_type'(s1_py_ff[j]) > s1_hiy_ff[j]) begin
            s2_qy_ff[j] <= s1_hiy_ff[j];
         end else begin
            s2_qy_ff[j] <= bound_type'(s1_py_ff[j]);
         end
         s2_px_ff[j] <= s1_px_ff[j];
         s2_py_ff[j] <= s1_py_ff[j];
         s3_dx_ff[j] <= rd_type'(s2_qx_ff[j]) - rd_type'(s2_px_ff[j]);
         s3_dy_ff[j] <= rd_type'(s2_qy_ff[j]) - rd_type'(s2_py_ff[j]);
         s4_sx_ff[j] <= RsqWidth'(s3_dx_ff[j] * s3_dx_ff[j]);
         s4_sy_ff[j] <= RsqWidth'(s3_dy_ff[j] * s3_dy_ff[j]);
         s5_rect_near_ff[j] <= (Rd2Width'(s4_sx_ff[j]) + Rd2Width'(s4_sy_ff[j])) <=
                               Rd2Width'(s4_r2_ff);
      end
   end

endmodule

// ----- tb/tb_shape_pair_overlap_test_unit.sv -----
`timescale 1ns / 1ps

module tb_shape_pair_overlap_test_unit;
   import spot_pkg::*;

   typedef struct {
      logic [2:0]  op;
      coord_type   ax0, ay0, ax1, ay1;
      logic [14:0] ar;
      coord_type   bx0, by0, bx1, by1;
      logic [14:0] br;
   } pair_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        pop = 1'b0;
   logic        full, empty, rsp_hit;
   logic [2:0]  req_op = '0;
   coord_type   req_a_x0 = '0, req_a_y0 = '0, req_a_x1 = '0, req_a_y1 = '0;
   coord_type   req_b_x0 = '0, req_b_y0 = '0, req_b_x1 = '0, req_b_y1 = '0;
   logic [14:0] req_a_radius = '0, req_b_radius = '0;

   pair_type    pair_queue[$];
   logic        expected_hits[$];
   pair_type    cur_pair;
   int          errors = 0;
   int          beats_in = 0;
   int          beats_out = 0;
   int          hits_seen = 0;
   int          cycles = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          holdoff_left = 0;
   bit          holdoff_done = 0;
   bit          beat_taken = 0;

   shape_pair_overlap_test_unit dut (.*);

   always #10 clock = ~clock;

   function automatic longint unsigned sum_sq(longint dx, longint dy);
      return longint'(dx * dx) + longint'(dy * dy);
   endfunction

   function automatic longint clamp_to(longint x, longint lo, longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
   endfunction

   function automatic longint unsigned rect_dist2(longint px, longint py, longint cx,
                                                  longint cy, longint hx, longint hy);
      longint qx, qy;
      qx = clamp_to(px, cx - hx, cx + hx);
      qy = clamp_to(py, cy - hy, cy + hy);
      return sum_sq(qx - px, qy - py);
   endfunction

   function automatic logic near_segment(longint px, longint py, longint ax, longint ay,
                                         longint bx, longint by, longint unsigned r2);
      longint unsigned len2, pa2;
      longint dot;
      logic [127:0] lhs, rhs;
      len2 = sum_sq(bx - ax, by - ay);
      pa2 = sum_sq(px - ax, py - ay);
      if (len2 == 0) return pa2 <= r2;
      dot = (px - ax) * (bx - ax) + (py - ay) * (by - ay);
      if (dot <= 0) return pa2 <= r2;
      if (longint'(unsigned'(dot)) >= len2 || dot >= longint'(len2))
         return sum_sq(px - bx, py - by) <= r2;
      // exact: |pa|^2*L2 - dot^2 <= r2*L2 without division
      lhs = 128'(pa2) * 128'(len2);
      rhs = 128'(r2) * 128'(len2) + 128'(dot) * 128'(dot);
      return lhs <= rhs;
   endfunction

   function automatic logic predict_overlap(pair_type p);
      longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, dx, dy;
      longint unsigned rs2, ar2, br2;
      ax0 = p.ax0; ay0 = p.ay0; ax1 = p.ax1; ay1 = p.ay1;
      bx0 = p.bx0; by0 = p.by0; bx1 = p.bx1; by1 = p.by1;
      rs2 = (longint'(p.ar) + longint'(p.br)) * (longint'(p.ar) + longint'(p.br));
      ar2 = longint'(p.ar) * longint'(p.ar);
      br2 = longint'(p.br) * longint'(p.br);
      case (p.op)
         OP_RECT_RECT: begin
            dx = ax0 - bx0; if (dx < 0) dx = -dx;
            dy = ay0 - by0; if (dy < 0) dy = -dy;
            return dx <= ax1 + bx1 && dy <= ay1 + by1;
         end
         OP_CIRCLE_CIRCLE: return sum_sq(ax0 - bx0, ay0 - by0) <= rs2;
         OP_CAPSULE_CAPSULE:
            return near_segment(ax0, ay0, bx0, by0, bx1, by1, rs2) ||
                   near_segment(ax1, ay1, bx0, by0, bx1, by1, rs2) ||
                   near_segment(bx0, by0, ax0, ay0, ax1, ay1, rs2) ||
                   near_segment(bx1, by1, ax0, ay0, ax1, ay1, rs2);
         OP_RECT_CIRCLE: return rect_dist2(bx0, by0, ax0, ay0, ax1, ay1) <= br2;
         OP_CAPSULE_CIRCLE: return near_segment(bx0, by0, ax0, ay0, ax1, ay1, rs2);
         OP_CAPSULE_RECT:
            return rect_dist2(ax0, ay0, bx0, by0, bx1, by1) <= ar2 ||
                   rect_dist2(ax1, ay1, bx0, by0, bx1, by1) <= ar2 ||
                   near_segment(bx0, by0, ax0, ay0, ax1, ay1, ar2);
         default: return 1'b0;
      endcase
   endfunction

   function automatic coord_type jitter(coord_type base, int spread);
      return coord_type'(int'(base) + int'($urandom_range(0, 2 * spread)) - spread);
   endfunction

   function automatic pair_type make_pair(logic [2:0] op, int ax0, int ay0, int ax1,
                                          int ay1, int ar, int bx0, int by0, int bx1,
                                          int by1, int br);
      pair_type p;
      p.op = op;
      p.ax0 = coord_type'(ax0); p.ay0 = coord_type'(ay0);
      p.ax1 = coord_type'(ax1); p.ay1 = coord_type'(ay1);
      p.ar = 15'(ar);
      p.bx0 = coord_type'(bx0); p.by0 = coord_type'(by0);
      p.bx1 = coord_type'(bx1); p.by1 = coord_type'(by1);
      p.br = 15'(br);
      return p;
   endfunction

   // input side: sample accepted beat at rising edge, drive at falling edge
   always @(posedge clock) begin
      beat_taken = !reset && push && !full;
      if (beat_taken) begin
         expected_hits.push_back(predict_overlap(cur_pair));
         beats_in++;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (!push || beat_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            push <= 1'b0;
         end else if (pair_queue.size() > 0) begin
            cur_pair = pair_queue.pop_front();
            req_op <= cur_pair.op;
            req_a_x0 <= cur_pair.ax0; req_a_y0 <= cur_pair.ay0;
            req_a_x1 <= cur_pair.ax1; req_a_y1 <= cur_pair.ay1;
            req_a_radius <= cur_pair.ar;
            req_b_x0 <= cur_pair.bx0; req_b_y0 <= cur_pair.by0;
            req_b_x1 <= cur_pair.bx1; req_b_y1 <= cur_pair.by1;
            req_b_radius <= cur_pair.br;
            push <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 12);
               // dense stretch with no gaps in the middle of the run
               gap_left = (beats_in > 600 && beats_in < 750) ? 0 : $urandom_range(0, 5);
            end
         end else begin
            push <= 1'b0;
         end
      end
   end

   // result side
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left--;
         pop <= 1'b0;
      end else if (!holdoff_done && beats_in >= 300) begin
         holdoff_done = 1;
         holdoff_left = 150;
         pop <= 1'b0;
      end else if (beats_in > 450 && beats_in < 600) begin
         pop <= 1'b1;
      end else begin
         pop <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (expected_hits.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual hit=%b", $realtime, rsp_hit);
            errors++;
         end else begin
            logic want;
            want = expected_hits.pop_front();
            if (rsp_hit !== want) begin
               $display("%0t: hit mismatch on beat %0d, expected %b, actual %b",
                        $realtime, beats_out, want, rsp_hit);
               errors++;
            end
         end
         beats_out++;
         if (rsp_hit === 1'b1) hits_seen++;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 200000) begin
         $display("%0t: timeout", $realtime);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      pair_type p;
      int       sel;
      // directed corners
      pair_queue.push_back(make_pair(OP_RECT_RECT, -32768, -32768, 32767, 32767, 0,
                                     32767, 32767, 32767, 32767, 32767));
      pair_queue.push_back(make_pair(OP_RECT_RECT, 0, 0, 5, 5, 0, 10, 10, 5, 5, 0));
      pair_queue.push_back(make_pair(OP_RECT_RECT, 0, 0, -3, 5, 0, 1, 0, 2, 5, 0));
      pair_queue.push_back(make_pair(OP_CIRCLE_CIRCLE, -32768, -32768, 0, 0, 32767,
                                     32767, 32767, 0, 0, 32767));
      pair_queue.push_back(make_pair(OP_CIRCLE_CIRCLE, 0, 0, 0, 0, 3, 7, 0, 0, 0, 4));
      pair_queue.push_back(make_pair(OP_CIRCLE_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // crossing capsules with far endpoints are missed
      pair_queue.push_back(make_pair(OP_CAPSULE_CAPSULE, -100, 0, 100, 0, 1,
                                     0, -100, 0, 100, 1));
      pair_queue.push_back(make_pair(OP_CAPSULE_CAPSULE, 0, 0, 0, 0, 2, 3, 0, 3, 0, 1));
      pair_queue.push_back(make_pair(OP_CAPSULE_CAPSULE, -32768, -32768, 32767, 32767,
                                     32767, 32767, -32768, -32768, 32767, 32767));
      pair_queue.push_back(make_pair(OP_RECT_CIRCLE, 0, 0, 10, 10, 0, 13, 14, 0, 0, 5));
      pair_queue.push_back(make_pair(OP_RECT_CIRCLE, 0, 0, -4, -4, 0, 3, 3, 0, 0, 1));
      pair_queue.push_back(make_pair(OP_RECT_CIRCLE, 32767, 32767, 32767, 32767, 0,
                                     -32768, -32768, 0, 0, 32767));
      // segment cases: degenerate, before start, past end, middle
      pair_queue.push_back(make_pair(OP_CAPSULE_CIRCLE, 5, 5, 5, 5, 2, 8, 9, 0, 0, 3));
      pair_queue.push_back(make_pair(OP_CAPSULE_CIRCLE, 0, 0, 10, 0, 1, -3, 0, 0, 0, 2));
      pair_queue.push_back(make_pair(OP_CAPSULE_CIRCLE, 0, 0, 10, 0, 1, 14, 0, 0, 0, 2));
      pair_queue.push_back(make_pair(OP_CAPSULE_CIRCLE, 0, 0, 10, 0, 1, 5, 3, 0, 0, 2));
      pair_queue.push_back(make_pair(OP_CAPSULE_CIRCLE, 0, 0, 10, 0, 1, 5, 4, 0, 0, 2));
      pair_queue.push_back(make_pair(OP_CAPSULE_RECT, -20, 0, 20, 0, 2, 0, 10, 3, 3, 0));
      pair_queue.push_back(make_pair(OP_CAPSULE_RECT, -20, 0, 20, 0, 2, 0, 8, 3, -3, 0));
      pair_queue.push_back(make_pair(OP_CAPSULE_RECT, -32768, 32767, 32767, -32768, 32767,
                                     0, 0, -32768, -32768, 32767));
      pair_queue.push_back(make_pair(3'd6, 0, 0, 1, 1, 1, 0, 0, 1, 1, 1));
      pair_queue.push_back(make_pair(3'd7, 0, 0, 1, 1, 1, 0, 0, 1, 1, 1));

      repeat (950) begin
         sel = $urandom_range(0, 9);
         p.op = ($urandom_range(0, 19) == 0) ? 3'(6 + $urandom_range(0, 1))
                                             : 3'($urandom_range(0, 5));
         p.ax0 = coord_type'($urandom);
         p.ay0 = coord_type'($urandom);
         if (sel == 0) begin
            // full-range noise
            p.ax1 = coord_type'($urandom); p.ay1 = coord_type'($urandom);
            p.ar = 15'($urandom);
            p.bx0 = coord_type'($urandom); p.by0 = coord_type'($urandom);
            p.bx1 = coord_type'($urandom); p.by1 = coord_type'($urandom);
            p.br = 15'($urandom);
         end else begin
            // shapes placed near each other so both outcomes are common
            int s;
            s = (sel < 4) ? 40 : 3000;
            if (p.op == OP_RECT_RECT || p.op == OP_RECT_CIRCLE) begin
               p.ax1 = coord_type'(int'($urandom_range(0, s)) - (sel == 9 ? s / 4 : 0));
               p.ay1 = coord_type'(int'($urandom_range(0, s)) - (sel == 9 ? s / 4 : 0));
            end else begin
               p.ax1 = jitter(p.ax0, s);
               p.ay1 = jitter(p.ay0, s);
            end
            p.ar = 15'($urandom_range(0, s / 2));
            p.bx0 = jitter(p.ax0, 2 * s);
            p.by0 = jitter(p.ay0, 2 * s);
            if (p.op == OP_RECT_RECT || p.op == OP_CAPSULE_RECT) begin
               p.bx1 = coord_type'(int'($urandom_range(0, s)) - (sel == 9 ? s / 4 : 0));
               p.by1 = coord_type'(int'($urandom_range(0, s)) - (sel == 9 ? s / 4 : 0));
            end else begin
               p.bx1 = jitter(p.bx0, s);
               p.by1 = jitter(p.by0, s);
            end
            p.br = 15'($urandom_range(0, s / 2));
         end
         pair_queue.push_back(p);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      wait (pair_queue.size() == 0 && !push);
      wait (expected_hits.size() == 0);
      repeat (20) @(posedge clock);
      $display("Ran %0d shape pairs over all opcodes, %0d results checked, %0d hits.",
               beats_in, beats_out, hits_seen);
      $display("Included a long result stall with the input backed up, and gap-free bursts.");
      if (errors == 0 && expected_hits.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/spot_pkg.sv
src/spot_front.sv
src/spot_cmd_queue.sv
src/spot_back.sv
src/shape_pair_overlap_test_unit.sv
tb/tb_shape_pair_overlap_test_unit.sv
